### sv/mm4_pkg.sv
// ----------------------------------------------------------------------------
// mm4_pkg
// Types and constants shared by the 4x4 fixed point matrix multiplier.
// ----------------------------------------------------------------------------
package mm4_pkg;

   localparam int DIM        = 4;
   localparam int IDX_WIDTH  = $clog2(DIM);
   localparam int ROW_WIDTH  = $clog2(2 * DIM);
   localparam int DATA_WIDTH = 16;
   localparam int FRAC_BITS  = 8;
   localparam int PROD_WIDTH = 2 * DATA_WIDTH;
   localparam int ACC_WIDTH  = PROD_WIDTH + IDX_WIDTH;

   typedef logic signed [DATA_WIDTH-1:0] elem_type;
   typedef elem_type [DIM-1:0]           vec_type;
   typedef vec_type [DIM-1:0]            mat_type;

   typedef struct packed {
      logic     row_start;
      elem_type in_col0;
      elem_type in_col1;
      elem_type in_col2;
      elem_type in_col3;
   } req_type;

   typedef struct packed {
      elem_type             out_col0;
      elem_type             out_col1;
      elem_type             out_col2;
      elem_type             out_col3;
      logic [IDX_WIDTH-1:0] row_index;
      logic                 row_last;
      logic                 clipped;
   } rsp_type;

   // product row being issued to the lanes
   typedef struct packed {
      logic                 valid;
      logic [IDX_WIDTH-1:0] index;
   } tag_type;

   typedef struct packed {
      logic     clip;
      elem_type value;
   } lane_out_type;

endpackage

### sv/mm4_ctrl.sv
// ----------------------------------------------------------------------------
// mm4_ctrl
// Row loader, matrix storage and product row sequencer.
// ----------------------------------------------------------------------------
module mm4_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  mm4_pkg::req_type req_data,
   output mm4_pkg::tag_type issue,
   output mm4_pkg::vec_type left_row,
   output mm4_pkg::mat_type right_rows
);
   import mm4_pkg::*;

   logic [ROW_WIDTH-1:0] rows_loaded_ff, rows_loaded_in;
   logic                 run_ff, run_in;
   logic [IDX_WIDTH-1:0] issue_row_ff, issue_row_in;
   mat_type              left_ff;
   mat_type              right_ff;
   logic [ROW_WIDTH-1:0] pos;
   logic                 last_row;
   vec_type              row_data;

   always_comb begin
      pos      = req_data.row_start ? '0 : rows_loaded_ff;
      last_row = (pos == ROW_WIDTH'(2 * DIM - 1));
      row_data = {req_data.in_col3, req_data.in_col2, req_data.in_col1, req_data.in_col0};

      rows_loaded_in = rows_loaded_ff;
      run_in         = run_ff;
      issue_row_in   = issue_row_ff;

      if (accept) begin
         rows_loaded_in = last_row ? '0 : pos + ROW_WIDTH'(1);
      end
      if (run_ff) begin
         issue_row_in = issue_row_ff + IDX_WIDTH'(1);
         if (issue_row_ff == IDX_WIDTH'(DIM - 1)) begin
            run_in = 1'b0;
         end
      end
      if (accept && last_row) begin
         run_in       = 1'b1;
         issue_row_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_loaded_ff <= '0;
         run_ff         <= 1'b0;
         issue_row_ff   <= '0;
      end else begin
         rows_loaded_ff <= rows_loaded_in;
         run_ff         <= run_in;
         issue_row_ff   <= issue_row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         if (pos[ROW_WIDTH-1]) begin
            right_ff[pos[IDX_WIDTH-1:0]] <= row_data;
         end else begin
            left_ff[pos[IDX_WIDTH-1:0]] <= row_data;
         end
      end
   end

   assign issue.valid = run_ff;
   assign issue.index = issue_row_ff;
   assign left_row    = left_ff[issue_row_ff];
   assign right_rows  = right_ff;

endmodule

### sv/mm4_lane.sv
// ----------------------------------------------------------------------------
// mm4_lane
// One output column: four products, then sum, floor shift and saturation.
// ----------------------------------------------------------------------------
module mm4_lane (
   input  logic                  clock,
   input  mm4_pkg::vec_type      row_a,
   input  mm4_pkg::vec_type      col_b,
   output mm4_pkg::lane_out_type result
);
   import mm4_pkg::*;

   localparam logic signed [ACC_WIDTH-1:0] SAT_MAX = ACC_WIDTH'((1 << (DATA_WIDTH - 1)) - 1);
   localparam logic signed [ACC_WIDTH-1:0] SAT_MIN = -SAT_MAX - ACC_WIDTH'(1);

   logic signed [PROD_WIDTH-1:0] prod_ff [DIM];
   logic signed [ACC_WIDTH-1:0]  acc;
   logic signed [ACC_WIDTH-1:0]  shifted;
   lane_out_type                 result_in;
   lane_out_type                 result_ff;

   always_ff @(posedge clock) begin
      for (int k = 0; k < DIM; k++) begin
         prod_ff[k] <= $signed(row_a[k]) * $signed(col_b[k]);
      end
   end

   always_comb begin
      acc = '0;
      for (int k = 0; k < DIM; k++) begin
         acc = acc + ACC_WIDTH'(prod_ff[k]);
      end
      shifted = acc >>> FRAC_BITS;
      if (shifted > SAT_MAX) begin
         result_in.value = SAT_MAX[DATA_WIDTH-1:0];
         result_in.clip  = 1'b1;
      end else if (shifted < SAT_MIN) begin
         result_in.value = SAT_MIN[DATA_WIDTH-1:0];
         result_in.clip  = 1'b1;
      end else begin
         result_in.value = shifted[DATA_WIDTH-1:0];
         result_in.clip  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign result = result_ff;

endmodule

### sv/mm4_merge.sv
// ----------------------------------------------------------------------------
// mm4_merge
// Aligns the row tag with the lanes and registers the merged result beat.
// ----------------------------------------------------------------------------
module mm4_merge (
   input  logic                  clock,
   input  logic                  reset,
   input  mm4_pkg::tag_type      issue,
   input  mm4_pkg::lane_out_type lane_res [mm4_pkg::DIM],
   output logic                  pending,
   output logic                  rsp_strobe,
   output mm4_pkg::rsp_type      rsp_data
);
   import mm4_pkg::*;

   tag_type tag1_ff, tag2_ff;
   logic    strobe_ff;
   rsp_type data_ff, data_in;

   always_comb begin
      data_in.out_col0  = lane_res[0].value;
      data_in.out_col1  = lane_res[1].value;
      data_in.out_col2  = lane_res[2].value;
      data_in.out_col3  = lane_res[3].value;
      data_in.row_index = tag2_ff.index;
      data_in.row_last  = (tag2_ff.index == IDX_WIDTH'(DIM - 1));
      data_in.clipped   = 1'b0;
      for (int c = 0; c < DIM; c++) begin
         data_in.clipped = data_in.clipped | lane_res[c].clip;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff   <= '0;
         tag2_ff   <= '0;
         strobe_ff <= 1'b0;
      end else begin
         tag1_ff   <= issue;
         tag2_ff   <= tag1_ff;
         strobe_ff <= tag2_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (tag2_ff.valid) begin
         data_ff <= data_in;
      end
   end

   assign pending    = tag1_ff.valid | tag2_ff.valid;
   assign rsp_strobe = strobe_ff;
   assign rsp_data   = data_ff;

endmodule

### sv/matrix_multiply_4x4_core.sv
// ----------------------------------------------------------------------------
// matrix_multiply_4x4_core
// 4x4 signed Q8.8 matrix multiplier: eight row beats in, four product rows out.
//
//   channel   ports                      direction   handshake
//   request   start, busy, req_data      in          start high while busy low
//   response  rsp_strobe, rsp_data       out         one cycle strobe, no stall
//
// A row beat is accepted while start is high and busy is low. After the eighth row,
// busy stays high while the rows are issued to the four column lanes and pass the
// lane registers (multiply, then sum and saturate). The four result beats follow
// on consecutive cycles from the merge register, after both lane registers.
// Reset clears the row count, the sequencer and the row tags; matrix contents are kept.
// ----------------------------------------------------------------------------
module matrix_multiply_4x4_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  mm4_pkg::req_type req_data,
   output logic             rsp_strobe,
   output mm4_pkg::rsp_type rsp_data
);
   import mm4_pkg::*;

   logic         accept;
   logic         pending;
   tag_type      issue;
   vec_type      left_row;
   mat_type      right_rows;
   vec_type      right_col [DIM];
   lane_out_type lane_res  [DIM];

   assign busy   = issue.valid | pending;
   assign accept = start & ~busy;

   mm4_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .req_data   (req_data),
      .issue      (issue),
      .left_row   (left_row),
      .right_rows (right_rows)
   );

   always_comb begin
      for (int c = 0; c < DIM; c++) begin
         for (int k = 0; k < DIM; k++) begin
            right_col[c][k] = right_rows[k][c];
         end
      end
   end

   for (genvar c = 0; c < DIM; c++) begin : g_lane
      mm4_lane u_lane (
         .clock  (clock),
         .row_a  (left_row),
         .col_b  (right_col[c]),
         .result (lane_res[c])
      );
   end

   mm4_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .issue      (issue),
      .lane_res   (lane_res),
      .pending    (pending),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

### sv/mm4_checker.sv
// ----------------------------------------------------------------------------
// mm4_checker
// Port level checks on the product row beats of the matrix multiplier.
// ----------------------------------------------------------------------------
module mm4_checker (
   input logic             clock,
   input logic             reset,
   input logic             busy,
   input logic             rsp_strobe,
   input mm4_pkg::rsp_type rsp_data
);
   import mm4_pkg::*;

   // rows of one product come back to back
   a_rows_contiguous: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.row_last |=> rsp_strobe)
      else $error("product rows not contiguous");

   a_index_steps: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.row_last |=>
         rsp_data.row_index == IDX_WIDTH'($past(rsp_data.row_index) + IDX_WIDTH'(1)))
      else $error("row index did not advance");

   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_data.row_last == (rsp_data.row_index == IDX_WIDTH'(DIM - 1)))
      else $error("last flag disagrees with row index");

   a_gap_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.row_last |=> !rsp_strobe)
      else $error("beat after last product row");

   // first row only follows a busy period
   a_first_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.row_index == '0 |-> $past(busy))
      else $error("product row without computation");

endmodule

bind matrix_multiply_4x4_core mm4_checker u_mm4_checker (
   .clock      (clock),
   .reset      (reset),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);
